// ----- hw/rtl/bscc_pkg.sv -----
`default_nettype none

package bscc_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned KEY_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY      = 2'd0,
        CFG_IV       = 2'd1,
        CFG_CHAINED  = 2'd2,
        CFG_DECRYPT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] iv;
        logic              chained;
        logic              decrypt;
    } cfg_t;

    // s(i) = ((i+1)*7 mod 17) - 1
    function automatic logic [3:0] sub_nib(input logic [3:0] n);
        logic [3:0] r;
        begin
            case (n)
                4'd0:    r = 4'd6;
                4'd1:    r = 4'd13;
                4'd2:    r = 4'd3;
                4'd3:    r = 4'd10;
                4'd4:    r = 4'd0;
                4'd5:    r = 4'd7;
                4'd6:    r = 4'd14;
                4'd7:    r = 4'd4;
                4'd8:    r = 4'd11;
                4'd9:    r = 4'd1;
                4'd10:   r = 4'd8;
                4'd11:   r = 4'd15;
                4'd12:   r = 4'd5;
                4'd13:   r = 4'd12;
                4'd14:   r = 4'd2;
                4'd15:   r = 4'd9;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [3:0] inv_nib(input logic [3:0] n);
        logic [3:0] r;
        begin
            case (n)
                4'd0:    r = 4'd4;
                4'd1:    r = 4'd9;
                4'd2:    r = 4'd14;
                4'd3:    r = 4'd2;
                4'd4:    r = 4'd7;
                4'd5:    r = 4'd12;
                4'd6:    r = 4'd0;
                4'd7:    r = 4'd5;
                4'd8:    r = 4'd10;
                4'd9:    r = 4'd15;
                4'd10:   r = 4'd3;
                4'd11:   r = 4'd8;
                4'd12:   r = 4'd13;
                4'd13:   r = 4'd1;
                4'd14:   r = 4'd6;
                4'd15:   r = 4'd11;
                default: r = 4'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [DATA_W-1:0] enc_round(input logic [DATA_W-1:0] b,
                                                    input logic [DATA_W-1:0] k);
        logic [DATA_W-1:0] s;
        begin
            s = {sub_nib(b[7:4]), sub_nib(b[3:0])};
            return {s[5:0], s[7:6]} ^ k;
        end
    endfunction

    function automatic logic [DATA_W-1:0] dec_round(input logic [DATA_W-1:0] b,
                                                    input logic [DATA_W-1:0] k);
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] r;
        begin
            x = b ^ k;
            r = {x[1:0], x[7:2]};
            return {inv_nib(r[7:4]), inv_nib(r[3:0])};
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bscc_cfg_regs.sv -----
`default_nettype none

module bscc_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bscc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bscc_pkg::KEY_W-1:0]     cfg_data,
    output bscc_pkg::cfg_t                      cfg
);

    bscc_pkg::cfg_t cfg_reg;
    bscc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (bscc_pkg::cfg_idx_t'(cfg_index))
                bscc_pkg::CFG_KEY:     cfg_next.key     = cfg_data;
                bscc_pkg::CFG_IV:      cfg_next.iv      = cfg_data[bscc_pkg::DATA_W-1:0];
                bscc_pkg::CFG_CHAINED: cfg_next.chained = cfg_data[0];
                bscc_pkg::CFG_DECRYPT: cfg_next.decrypt = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key     <= '0;
            cfg_reg.iv      <= '0;
            cfg_reg.chained <= 1'b1;
            cfg_reg.decrypt <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bscc_datapath.sv -----
`default_nettype none

module bscc_datapath (
    input  wire bscc_pkg::cfg_t              cfg,
    input  wire logic [bscc_pkg::DATA_W-1:0] data_in,
    input  wire logic                        start,
    input  wire logic [bscc_pkg::DATA_W-1:0] chain,
    output logic      [bscc_pkg::DATA_W-1:0] result,
    output logic      [bscc_pkg::DATA_W-1:0] chain_next
);

    logic [bscc_pkg::DATA_W-1:0] k1;
    logic [bscc_pkg::DATA_W-1:0] k2;
    logic [bscc_pkg::DATA_W-1:0] mix;
    logic [bscc_pkg::DATA_W-1:0] enc_mid;
    logic [bscc_pkg::DATA_W-1:0] enc_out;
    logic [bscc_pkg::DATA_W-1:0] dec_mid;
    logic [bscc_pkg::DATA_W-1:0] dec_out;

    assign k1  = cfg.key[bscc_pkg::KEY_W-1:bscc_pkg::DATA_W];
    assign k2  = cfg.key[bscc_pkg::DATA_W-1:0];
    assign mix = cfg.chained ? (start ? cfg.iv : chain) : '0;

    assign enc_mid = bscc_pkg::enc_round(data_in ^ mix, k1);
    assign enc_out = bscc_pkg::enc_round(enc_mid, k2);

    // undo round two first, then round one
    assign dec_mid = bscc_pkg::dec_round(data_in, k2);
    assign dec_out = bscc_pkg::dec_round(dec_mid, k1) ^ mix;

    assign result     = cfg.decrypt ? dec_out : enc_out;
    assign chain_next = cfg.decrypt ? data_in : enc_out;

endmodule

`default_nettype wire

// ----- hw/rtl/byte_spn_cipher_cbc.sv -----
// Input stage registers an accepted byte; output stage registers its result for m_axis.
// Throughput: one byte per cycle unless m_axis stalls; chain_reg alone closes the chain loop.
// The input stalls only while both stages hold a byte and m_axis_tready is low.
// Reset (rst_n low, asynchronous): both stages empty, chain byte 0, key and IV 0,
// chained mode on, encrypt mode.
`default_nettype none

module byte_spn_cipher_cbc (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [bscc_pkg::DATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  wire logic                           s_axis_tuser,  // [0] message_start
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic      [bscc_pkg::DATA_W-1:0]    m_axis_tdata,  // [7:0] result_byte
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bscc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bscc_pkg::KEY_W-1:0]     cfg_data
);

    bscc_pkg::cfg_t cfg;

    logic                        in_valid_reg;
    logic                        in_valid_next;
    logic [bscc_pkg::DATA_W-1:0] in_data_reg;
    logic                        in_start_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [bscc_pkg::DATA_W-1:0] out_data_reg;
    logic [bscc_pkg::DATA_W-1:0] chain_reg;
    logic [bscc_pkg::DATA_W-1:0] result;
    logic [bscc_pkg::DATA_W-1:0] chain_next;
    logic                        out_free;
    logic                        advance;
    logic                        in_take;

    bscc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bscc_datapath u_dp (
        .cfg        (cfg),
        .data_in    (in_data_reg),
        .start      (in_start_reg),
        .chain      (chain_reg),
        .result     (result),
        .chain_next (chain_next)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            chain_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (advance)
            out_data_reg <= result;
    end

    // chain follows the ciphertext produced when encrypting
    a_enc_chain: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !cfg.decrypt |=> chain_reg == out_data_reg)
        else $error("chain byte does not match the last ciphertext");

    // chain follows the ciphertext consumed when decrypting
    a_dec_chain: assert property (@(posedge clk) disable iff (!rst_n)
        advance && cfg.decrypt |=> chain_reg == $past(in_data_reg))
        else $error("chain byte does not match the last input ciphertext");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled while the pipeline has room");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without an item in the input stage");

endmodule

`default_nettype wire
